>>> hw/rtl/mtig_pkg.sv
// shared types and constants for the mesh triangle index generator
// no dependencies; imported by mtig_seq, mesh_triangle_index_generator and the testbench
package mtig_pkg;

    localparam int VTX_W          = 16;
    localparam int SLOT_W         = 17;
    localparam int CFG_SIDE_W     = 9;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_INDEX_BITS = 16;
    localparam int DEF_MAX_SIDE   = 256;

    typedef enum logic [1:0] {
        MODE_GRID   = 2'd0,
        MODE_HOLLOW = 2'd1,
        MODE_FAN    = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_ROWS   = 3'd1,
        REG_COLS   = 3'd2,
        REG_VBASE  = 3'd3,
        REG_TBASE  = 3'd4,
        REG_CENTER = 3'd5,
        REG_CCW    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [CFG_SIDE_W-1:0] rows;
        logic [CFG_SIDE_W-1:0] cols;
        logic [VTX_W-1:0]      vbase;
        logic [SLOT_W-1:0]     tbase;
        logic [VTX_W-1:0]      center;
        logic                  ccw;
    } cfg_t;

    // per-item control that rides along the datapath
    typedef struct packed {
        logic emit;
        logic last;
        logic fan;
        logic closing;
        logic half;
        logic wrap;
        logic swap;
    } tri_ctl_t;

    localparam logic [1:0]            RST_MODE   = 2'd0;
    localparam logic [CFG_SIDE_W-1:0] RST_ROWS   = 9'd2;
    localparam logic [CFG_SIDE_W-1:0] RST_COLS   = 9'd2;
    localparam logic [VTX_W-1:0]      RST_VBASE  = 16'd0;
    localparam logic [SLOT_W-1:0]     RST_TBASE  = 17'd0;
    localparam logic [VTX_W-1:0]      RST_CENTER = 16'd0;
    localparam logic                  RST_CCW    = 1'b1;

endpackage

>>> hw/rtl/mtig_seq.sv
// pattern sequencer: column/row/pair counters, running count and first pipeline stage
// depends on mtig_pkg
module mtig_seq #(
    parameter int MAX_SIDE = 256,
    localparam int POS_W  = $clog2(MAX_SIDE),
    localparam int SIDE_W = $clog2(MAX_SIDE + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        stage_en,
    input  logic                        in_valid,
    input  logic                        restart,
    input  mtig_pkg::cfg_t              cfg,
    output logic                        out_valid,
    output mtig_pkg::tri_ctl_t          ctl,
    output logic [POS_W-1:0]            col,
    output logic [POS_W-1:0]            row,
    output logic [mtig_pkg::SLOT_W-1:0] slot,
    output logic [SIDE_W-1:0]           side_m
);
    import mtig_pkg::*;

    localparam int CMP_W = (SIDE_W > CFG_SIDE_W) ? SIDE_W : CFG_SIDE_W;

    logic [POS_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic              half_reg, half_next, close_reg, close_next;
    logic              fin_reg, fin_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              vld_reg;
    tri_ctl_t          ctl_reg, ctl_next;
    logic [POS_W-1:0]  col_out_reg, row_out_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [CMP_W-1:0]  rows_x, cols_x, max_x, m_x, n_x;
    logic [SIDE_W-1:0] m_c, n_c;
    logic [POS_W-1:0]  col_e, row_e;
    logic              half_e, close_e, fin_e;
    logic [SLOT_W-1:0] cnt_e;
    logic              mode_ok, is_fan, is_hollow, idle, col_end, row_more;
    logic              accept;

    assign accept = stage_en && in_valid;

    // sides saturated into their legal ranges
    always_comb begin
        rows_x = CMP_W'(cfg.rows);
        cols_x = CMP_W'(cfg.cols);
        max_x  = CMP_W'(MAX_SIDE);
        if (rows_x < CMP_W'(2)) begin
            m_x = CMP_W'(2);
        end else if (rows_x > max_x) begin
            m_x = max_x;
        end else begin
            m_x = rows_x;
        end
        if (cols_x < CMP_W'(1)) begin
            n_x = CMP_W'(1);
        end else if (cols_x > max_x) begin
            n_x = max_x;
        end else begin
            n_x = cols_x;
        end
        m_c = SIDE_W'(m_x);
        n_c = SIDE_W'(n_x);
    end

    always_comb begin
        is_fan    = (cfg.mode == MODE_FAN);
        is_hollow = (cfg.mode == MODE_HOLLOW);
        mode_ok   = (cfg.mode == MODE_GRID) || is_hollow || is_fan;

        col_e   = restart ? '0 : col_reg;
        row_e   = restart ? '0 : row_reg;
        half_e  = restart ? 1'b0 : half_reg;
        close_e = restart ? 1'b0 : close_reg;
        cnt_e   = restart ? '0 : cnt_reg;
        fin_e   = restart ? !mode_ok : fin_reg;
        idle    = fin_e || !mode_ok;

        col_end  = (SIDE_W'(col_e) + SIDE_W'(1)) >= n_c;
        row_more = (SIDE_W'(row_e) + SIDE_W'(2)) < m_c;

        col_next   = col_reg;
        row_next   = row_reg;
        half_next  = half_reg;
        close_next = close_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;

        if (accept) begin
            col_next   = col_e;
            row_next   = row_e;
            half_next  = half_e;
            close_next = close_e;
            cnt_next   = cnt_e;
            fin_next   = fin_e;
            if (idle) begin
                fin_next = 1'b1;
            end else begin
                cnt_next = cnt_e + SLOT_W'(1);
                if (is_fan) begin
                    if (col_end) begin
                        fin_next = 1'b1;
                    end else begin
                        col_next = col_e + POS_W'(1);
                    end
                end else if (!half_e) begin
                    half_next = 1'b1;
                end else begin
                    half_next  = 1'b0;
                    close_next = 1'b0;
                    if (is_hollow && close_e) begin
                        row_next = '0;
                        if (col_end) begin
                            fin_next = 1'b1;
                        end else begin
                            col_next = col_e + POS_W'(1);
                        end
                    end else if (row_more) begin
                        row_next = row_e + POS_W'(1);
                    end else begin
                        row_next = '0;
                        if (is_hollow) begin
                            close_next = 1'b1;
                        end else if (col_end) begin
                            fin_next = 1'b1;
                        end else begin
                            col_next = col_e + POS_W'(1);
                        end
                    end
                end
            end
        end

        ctl_next.emit    = !idle;
        ctl_next.last    = !idle && fin_next;
        ctl_next.fan     = is_fan;
        ctl_next.closing = is_hollow && close_e;
        ctl_next.half    = half_e;
        ctl_next.wrap    = col_end;
        ctl_next.swap    = !cfg.ccw && !is_hollow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            half_reg  <= 1'b0;
            close_reg <= 1'b0;
            cnt_reg   <= '0;
            fin_reg   <= 1'b1;
            vld_reg   <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            half_reg  <= half_next;
            close_reg <= close_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
            if (stage_en) begin
                vld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_reg     <= ctl_next;
            col_out_reg <= col_e;
            row_out_reg <= row_e;
            slot_reg    <= cfg.tbase + cnt_e;
        end
    end

    assign out_valid = vld_reg;
    assign ctl       = ctl_reg;
    assign col       = col_out_reg;
    assign row       = row_out_reg;
    assign slot      = slot_reg;
    assign side_m    = m_c;

endmodule

>>> hw/rtl/mesh_triangle_index_generator.sv
// Triangle index generator for a revolved mesh part (grid, hollow and fan patterns).
// Channels: s_ (requests), m_ (triangles), cfg_ (register writes). Depends on mtig_pkg
// and mtig_seq.
//
// Each request item on s_ carries a restart flag in s_tdata[0]; restart starts the
// pattern from its first triangle, otherwise the next triangle is produced. Every
// request gives exactly one m_ item: m_tuser high with the triangle slot and three
// corner indices in m_tdata, m_tlast on the final triangle; m_tuser low and all zero
// fields once the pattern is finished or the mode is unused.
// From acceptance an item passes the sequencer stage, the column-base multiply, the
// base adds, then the corner add and ordering into the output register.
// Throughput is one item per cycle; every stage moves together whenever the output
// register is empty or being taken, so a stalled receiver holds the whole pipeline
// and s_tready drops. Reset leaves the pattern finished until a restart arrives and
// loads the register defaults. Registers are written on cfg_ at any time
// (cfg_ready stays high) but are meant to change only while no item is in flight.
module mesh_triangle_index_generator #(
    parameter int INDEX_BITS = mtig_pkg::DEF_INDEX_BITS,
    parameter int MAX_SIDE   = mtig_pkg::DEF_MAX_SIDE
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] restart
    // triangle channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [71:0]                    m_tdata,   // [16:0] slot, [32:17] a,
                                                      // [48:33] b, [64:49] c
    output logic                           m_tuser,   // valid_res
    output logic                           m_tlast,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mtig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mtig_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtig_pkg::*;

    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int PROD_W = POS_W + SIDE_W;
    localparam logic [VTX_W-1:0] IDX_MASK = (INDEX_BITS >= VTX_W) ? {VTX_W{1'b1}} :
        VTX_W'((64'd1 << INDEX_BITS) - 64'd1);

    cfg_t cfg_reg;

    logic              stage_en;
    logic              a_vld;
    tri_ctl_t          a_ctl;
    logic [POS_W-1:0]  a_col, a_row;
    logic [SLOT_W-1:0] a_slot;
    logic [SIDE_W-1:0] side_m;
    logic [PROD_W-1:0] prod_full;

    logic              b_vld_reg;
    tri_ctl_t          b_ctl_reg;
    logic [VTX_W-1:0]  b_prod_reg;
    logic [POS_W-1:0]  b_row_reg;
    logic [SLOT_W-1:0] b_slot_reg;

    logic              c_vld_reg;
    tri_ctl_t          c_ctl_reg;
    logic [VTX_W-1:0]  c_i_reg, c_s_reg, c_b1_reg;
    logic [VTX_W-1:0]  c_off0_reg, c_off1_reg, c_off2_reg;
    logic [SLOT_W-1:0] c_slot_reg;

    logic [VTX_W-1:0]  m16, row16, row1, mm1, base_i, base_s;
    logic [VTX_W-1:0]  t0, t1, t2;

    logic              out_vld_reg;
    logic [71:0]       out_data_reg;
    logic              out_user_reg, out_last_reg;

    // register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= RST_MODE;
            cfg_reg.rows   <= RST_ROWS;
            cfg_reg.cols   <= RST_COLS;
            cfg_reg.vbase  <= RST_VBASE;
            cfg_reg.tbase  <= RST_TBASE;
            cfg_reg.center <= RST_CENTER;
            cfg_reg.ccw    <= RST_CCW;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[1:0];
                REG_ROWS:   cfg_reg.rows   <= cfg_data[CFG_SIDE_W-1:0];
                REG_COLS:   cfg_reg.cols   <= cfg_data[CFG_SIDE_W-1:0];
                REG_VBASE:  cfg_reg.vbase  <= cfg_data[VTX_W-1:0];
                REG_TBASE:  cfg_reg.tbase  <= cfg_data[SLOT_W-1:0];
                REG_CENTER: cfg_reg.center <= cfg_data[VTX_W-1:0];
                REG_CCW:    cfg_reg.ccw    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign stage_en = !out_vld_reg || m_tready;
    assign s_tready = stage_en;

    mtig_seq #(
        .MAX_SIDE(MAX_SIDE)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stage_en (stage_en),
        .in_valid (s_tvalid),
        .restart  (s_tdata[0]),
        .cfg      (cfg_reg),
        .out_valid(a_vld),
        .ctl      (a_ctl),
        .col      (a_col),
        .row      (a_row),
        .slot     (a_slot),
        .side_m   (side_m)
    );

    // column base offset, wraps at the index width
    assign prod_full = PROD_W'(a_col) * PROD_W'(side_m);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (stage_en) begin
            b_vld_reg <= a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            b_ctl_reg  <= a_ctl;
            b_prod_reg <= VTX_W'(prod_full);
            b_row_reg  <= a_row;
            b_slot_reg <= a_slot;
        end
    end

    // first vertex of this column and of the next one, plus per-corner offsets
    always_comb begin
        m16    = VTX_W'(side_m);
        row16  = VTX_W'(b_row_reg);
        row1   = row16 + VTX_W'(1);
        mm1    = m16 - VTX_W'(1);
        base_i = cfg_reg.vbase + b_prod_reg;
        base_s = b_ctl_reg.wrap ? cfg_reg.vbase : cfg_reg.vbase + b_prod_reg + m16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (stage_en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            c_ctl_reg  <= b_ctl_reg;
            c_slot_reg <= b_slot_reg;
            c_i_reg    <= base_i;
            c_s_reg    <= base_s;
            c_b1_reg   <= (b_ctl_reg.half && !b_ctl_reg.fan) ? base_s : base_i;
            c_off0_reg <= b_ctl_reg.closing ? mm1 : row16;
            c_off1_reg <= b_ctl_reg.closing ? '0 : row1;
            if (b_ctl_reg.closing) begin
                c_off2_reg <= b_ctl_reg.half ? mm1 : '0;
            end else begin
                c_off2_reg <= b_ctl_reg.half ? row16 : row1;
            end
        end
    end

    always_comb begin
        if (c_ctl_reg.fan) begin
            t0 = cfg_reg.center;
            t1 = c_i_reg;
            t2 = c_s_reg;
        end else begin
            t0 = c_i_reg + c_off0_reg;
            t1 = c_b1_reg + c_off1_reg;
            t2 = c_s_reg + c_off2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (stage_en) begin
            out_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            out_user_reg <= c_ctl_reg.emit;
            out_last_reg <= c_ctl_reg.last;
            if (!c_ctl_reg.emit) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg[71:65] <= '0;
                out_data_reg[16:0]  <= c_slot_reg;
                out_data_reg[32:17] <= t0 & IDX_MASK;
                out_data_reg[48:33] <= (c_ctl_reg.swap ? t2 : t1) & IDX_MASK;
                out_data_reg[64:49] <= (c_ctl_reg.swap ? t1 : t2) & IDX_MASK;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // a finished-pattern item carries nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && (m_tdata == '0))
        else $error("empty item carries data or last");

    // with the receiver held ready an accepted item reaches the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready [*3] |=> m_tvalid)
        else $error("accepted item did not reach the output in time");

endmodule

>>> dv/mesh_triangle_index_generator_tb.sv
// self-checking testbench for mesh_triangle_index_generator: grid, hollow and fan patterns
// predicted per request and checked on the triangle channel; needs mtig_pkg and the rtl
`timescale 1ns / 100ps

module mesh_triangle_index_generator_tb;
    import mtig_pkg::*;

    typedef struct packed {
        logic        valid_res;
        logic [16:0] slot;
        logic [15:0] vtx_a;
        logic [15:0] vtx_b;
        logic [15:0] vtx_c;
        logic        last;
    } triangle_t;

    class mesh_triangle_tracker;
        logic [1:0]  mode   = RST_MODE;
        logic [8:0]  rows   = RST_ROWS;
        logic [8:0]  cols   = RST_COLS;
        logic [15:0] vbase  = RST_VBASE;
        logic [16:0] tbase  = RST_TBASE;
        logic [15:0] center = RST_CENTER;
        logic        ccw    = RST_CCW;

        int          col_pos   = 0;
        int          row_pos   = 0;
        bit          pair_half = 0;
        bit          closing   = 0;
        bit          finished  = 1;
        logic [16:0] emitted   = '0;

        triangle_t   expected_triangles[$];
        int          checked = 0;
        int          errors  = 0;

        function void write_reg(logic [2:0] idx, logic [16:0] value);
            case (idx)
                REG_MODE:   mode   = value[1:0];
                REG_ROWS:   rows   = value[8:0];
                REG_COLS:   cols   = value[8:0];
                REG_VBASE:  vbase  = value[15:0];
                REG_TBASE:  tbase  = value;
                REG_CENTER: center = value[15:0];
                REG_CCW:    ccw    = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_triangles.size();
        endfunction

        function bit pattern_done();
            return finished;
        endfunction

        function bit mode_known();
            return (mode == MODE_GRID) || (mode == MODE_HOLLOW) || (mode == MODE_FAN);
        endfunction

        function void close_column(int n);
            if (col_pos + 1 >= n)
                finished = 1;
            else
                col_pos++;
        endfunction

        // works out the triangle one request gives and moves the pattern on
        function void note_request(bit restart);
            int        m, n, c, i, s, j, q, t0, t1, t2, x;
            bit        swap;
            triangle_t exp_tri;
            m = (rows < 2) ? 2 : (rows > 256) ? 256 : int'(rows);
            n = (cols < 1) ? 1 : (cols > 256) ? 256 : int'(cols);
            exp_tri = '0;
            if (restart) begin
                col_pos   = 0;
                row_pos   = 0;
                pair_half = 0;
                closing   = 0;
                emitted   = '0;
                finished  = !mode_known();
            end
            if (finished || !mode_known()) begin
                finished = 1;
                expected_triangles.push_back(exp_tri);
                return;
            end
            c = col_pos;
            i = int'(vbase) + c * m;
            s = (c + 1 >= n) ? int'(vbase) : i + m;
            swap = !ccw;
            if (mode == MODE_FAN) begin
                t0 = int'(center);
                t1 = i;
                t2 = s;
            end else if (mode == MODE_HOLLOW && closing) begin
                // closing pair joins the last row to the first
                swap = 0;
                t0 = i + m - 1;
                t1 = pair_half ? s : i;
                t2 = pair_half ? s + m - 1 : s;
            end else begin
                if (mode == MODE_HOLLOW)
                    swap = 0;
                j = i + row_pos;
                q = s + row_pos;
                t0 = j;
                t1 = pair_half ? q + 1 : j + 1;
                t2 = pair_half ? q : q + 1;
            end
            if (swap) begin
                x  = t1;
                t1 = t2;
                t2 = x;
            end
            exp_tri.valid_res = 1'b1;
            exp_tri.slot      = tbase + emitted;
            exp_tri.vtx_a     = t0[15:0];
            exp_tri.vtx_b     = t1[15:0];
            exp_tri.vtx_c     = t2[15:0];
            emitted           = emitted + 1'b1;

            if (mode == MODE_FAN) begin
                close_column(n);
            end else if (!pair_half) begin
                pair_half = 1;
            end else begin
                pair_half = 0;
                if (mode == MODE_HOLLOW && closing) begin
                    closing = 0;
                    row_pos = 0;
                    close_column(n);
                end else begin
                    closing = 0;
                    if (row_pos + 1 < m - 1) begin
                        row_pos++;
                    end else begin
                        row_pos = 0;
                        if (mode == MODE_HOLLOW)
                            closing = 1;
                        else
                            close_column(n);
                    end
                end
            end
            exp_tri.last = finished;
            expected_triangles.push_back(exp_tri);
        endfunction

        task report(string what);
            $display("mismatch at triangle %0d: %s", checked, what);
            errors++;
        endtask

        task check_triangle(triangle_t got);
            triangle_t want;
            if (expected_triangles.size() == 0) begin
                report($sformatf("no triangle pending, got %h", got));
                return;
            end
            want = expected_triangles.pop_front();
            if (got.valid_res !== want.valid_res)
                report($sformatf("valid_res got %h expected %h", got.valid_res, want.valid_res));
            if (got.slot !== want.slot)
                report($sformatf("slot got %h expected %h", got.slot, want.slot));
            if (got.vtx_a !== want.vtx_a)
                report($sformatf("vertex_a got %h expected %h", got.vtx_a, want.vtx_a));
            if (got.vtx_b !== want.vtx_b)
                report($sformatf("vertex_b got %h expected %h", got.vtx_b, want.vtx_b));
            if (got.vtx_c !== want.vtx_c)
                report($sformatf("vertex_c got %h expected %h", got.vtx_c, want.vtx_c));
            if (got.last !== want.last)
                report($sformatf("last got %h expected %h", got.last, want.last));
            checked++;
        endtask
    endclass

    localparam int         LATENCY     = 3;
    localparam int         ITEM_TARGET = 1550;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [0] restart
    logic                  m_tvalid;
    logic                  m_tready;
    logic [71:0]           m_tdata;    // [16:0] slot, [32:17] a, [48:33] b, [64:49] c
    logic                  m_tuser;    // valid_res
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mesh_triangle_tracker board;
    mode_t grid_modes[3] = '{MODE_GRID, MODE_HOLLOW, MODE_FAN};
    int    items_sent  = 0;
    int    cycle_count = 0;
    int    stall_left  = 0;
    bit    gaps_on     = 1;
    bit    stall_on    = 1;

    mesh_triangle_index_generator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (stall_left > 0)
            stall_left--;
        else if (stall_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        m_tready <= (stall_left == 0);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_triangle({m_tuser, m_tdata[16:0], m_tdata[32:17], m_tdata[48:33],
                                  m_tdata[64:49], m_tlast});
    end

    // leaves cfg_valid high so writes can go back to back; caller lowers it
    task automatic write_reg(logic [2:0] idx, logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, value);
    endtask

    task automatic send_request(bit restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        board.note_request(restart);
        items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    function automatic int pick_side(int lo);
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(lo, 6);
        if (r < 93)
            return $urandom_range(0, lo);    // at or below the minimum, saturates up
        if (r < 96)
            return 256;
        return $urandom_range(0, 511);
    endfunction

    initial begin
        int         kind;
        int         count;
        logic [1:0] mode_pick;
        board     = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // idle after reset until the first restart
        send_request(1'b0);
        // default 2x2 grid: four triangles, then finished
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        drain();

        // hollow single column with wrapping indices and slots, order never swapped
        write_reg(REG_MODE, 17'(MODE_HOLLOW));
        write_reg(REG_ROWS, 17'd3);
        write_reg(REG_COLS, 17'd1);
        write_reg(REG_VBASE, 17'h0FFFE);
        write_reg(REG_TBASE, 17'h1FFFE);
        write_reg(REG_CCW, 17'd0);
        write_reg(REG_UNUSED, 17'h1FFFF);
        cfg_valid <= 1'b0;
        send_request(1'b1);
        repeat (6) send_request(1'b0);
        drain();

        // fan, rows above the maximum, swapped corners
        write_reg(REG_MODE, 17'(MODE_FAN));
        write_reg(REG_ROWS, 17'd511);
        write_reg(REG_COLS, 17'd3);
        write_reg(REG_CENTER, 17'h0FFFF);
        cfg_valid <= 1'b0;
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        write_reg(REG_MODE, 17'(MODE_UNUSED));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        drain();

        // zero sides saturate to the minimum
        write_reg(REG_MODE, 17'(MODE_GRID));
        write_reg(REG_ROWS, 17'd0);
        write_reg(REG_COLS, 17'd0);
        write_reg(REG_CCW, 17'd1);
        cfg_valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b0);

        while (items_sent < ITEM_TARGET) begin
            drain();
            if (items_sent >= ITEM_TARGET - 200) begin
                gaps_on  = 0;
                stall_on = 0;
            end else begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            write_reg(REG_ROWS, 17'(pick_side(2)));
            write_reg(REG_COLS, 17'(pick_side(1)));
            if ($urandom_range(0, 1)) begin
                mode_pick = ($urandom_range(0, 24) == 0) ? MODE_UNUSED
                                                         : grid_modes[$urandom_range(0, 2)];
                write_reg(REG_MODE, 17'(mode_pick));
            end
            if ($urandom_range(0, 1))
                write_reg(REG_VBASE, 17'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(64935, 65535)
                                         : $urandom_range(0, 65535)));
            if ($urandom_range(0, 1))
                write_reg(REG_TBASE, 17'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(130471, 131071)
                                         : $urandom_range(0, 131071)));
            if ($urandom_range(0, 1))
                write_reg(REG_CENTER, 17'($urandom_range(0, 65535)));
            if ($urandom_range(0, 1))
                write_reg(REG_CCW, 17'($urandom_range(0, 1)));
            cfg_valid <= 1'b0;

            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                // whole pattern, sometimes asked past its end
                send_request(1'b1);
                count = 1;
                while (!board.pattern_done() && count < 300 && items_sent < ITEM_TARGET) begin
                    send_request(1'b0);
                    count++;
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_request(1'b0);
            end else if (kind < 85) begin
                // carry on an unfinished pattern under the new registers
                repeat ($urandom_range(1, 20)) send_request(1'b0);
            end else begin
                repeat ($urandom_range(1, 30)) send_request($urandom_range(0, 6) == 0);
            end
        end

        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mtig_pkg.sv
hw/rtl/mtig_seq.sv
hw/rtl/mesh_triangle_index_generator.sv
dv/mesh_triangle_index_generator_tb.sv
